// File: design/vru_pkg.sv
// Package for the vector refraction unit: transaction types, fixed-point constants, rounding.
`timescale 1ns / 1ps
package vru_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int NORM_EXTRA = 14;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 20;
    localparam int ACC_W      = 48;

    typedef struct packed {
        logic signed [IN_W-1:0] dir_x;
        logic signed [IN_W-1:0] dir_y;
        logic signed [IN_W-1:0] dir_z;
        logic signed [IN_W-1:0] normal_x;
        logic signed [IN_W-1:0] normal_y;
        logic signed [IN_W-1:0] normal_z;
        logic        [IN_W-1:0] index_ratio;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_x;
        logic signed [OUT_W-1:0] out_y;
        logic signed [OUT_W-1:0] out_z;
        logic                    refracted;
    } t_out;

    // shift right by FRAC_BITS, rounding half away from zero
    function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] mag;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        mag = (mag + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[ACC_W-1] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// File: design/vru_isqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with remainder and sideband.
`timescale 1ns / 1ps
module vru_isqrt_pipe #(
    parameter int X_W  = 60,
    parameter int SB_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [X_W-1:0]    i_x,
    input  logic [SB_W-1:0]   i_sb,
    output logic              o_vld,
    output logic [X_W/2-1:0]  o_root,
    output logic [X_W/2+1:0]  o_rem,
    output logic [SB_W-1:0]   o_sb
);
    localparam int RW    = X_W / 2;
    localparam int REM_W = RW + 2;

    logic [RW:0]        r_vld;
    logic [REM_W-1:0]   r_rem  [RW+1];
    logic [RW-1:0]      r_root [RW+1];
    logic [X_W-1:0]     r_x    [RW+1];
    logic [SB_W-1:0]    r_sb   [RW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[RW-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_x[0]    <= i_x;
        r_sb[0]   <= i_sb;
    end

    for (genvar g = 0; g < RW; g++) begin : g_step
        logic [REM_W-1:0] n_rem_in;
        logic [REM_W-1:0] n_trial;
        logic [REM_W-1:0] n_rem;
        logic [RW-1:0]    n_root;

        always_comb begin
            n_rem_in = {r_rem[g][REM_W-3:0], r_x[g][X_W-1 -: 2]};
            n_trial  = {r_root[g], 2'b01};
            if (n_rem_in >= n_trial) begin
                n_rem  = n_rem_in - n_trial;
                n_root = {r_root[g][RW-2:0], 1'b1};
            end else begin
                n_rem  = n_rem_in;
                n_root = {r_root[g][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= n_rem;
            r_root[g+1] <= n_root;
            r_x[g+1]    <= {r_x[g][X_W-3:0], 2'b00};
            r_sb[g+1]   <= r_sb[g];
        end
    end

    assign o_vld  = r_vld[RW];
    assign o_root = r_root[RW];
    assign o_rem  = r_rem[RW];
    assign o_sb   = r_sb[RW];

endmodule

// File: design/vru_div_pipe.sv
// Pipelined restoring divider, lanes sharing one divisor, one quotient bit per stage.
`timescale 1ns / 1ps
module vru_div_pipe #(
    parameter int NL    = 3,
    parameter int DVD_W = 45,
    parameter int DVS_W = 30,
    parameter int QW    = 16,
    parameter int SB_W  = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [NL-1:0][DVD_W-1:0]   i_dvd,
    input  logic [DVS_W-1:0]           i_dvs,
    input  logic [SB_W-1:0]            i_sb,
    output logic                       o_vld,
    output logic [NL-1:0][QW-1:0]      o_quo,
    output logic [SB_W-1:0]            o_sb
);
    localparam int REM_W = DVS_W + 1;

    logic [QW:0]                    r_vld;
    logic [NL-1:0][REM_W-1:0]       r_rem [QW+1];
    logic [NL-1:0][QW-1:0]          r_low [QW+1];
    logic [NL-1:0][QW-1:0]          r_quo [QW+1];
    logic [DVS_W-1:0]               r_dvs [QW+1];
    logic [SB_W-1:0]                r_sb  [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QW-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r_rem[0][l] <= REM_W'(i_dvd[l][DVD_W-1:QW]);
            r_low[0][l] <= i_dvd[l][QW-1:0];
            r_quo[0][l] <= '0;
        end
        r_dvs[0] <= i_dvs;
        r_sb[0]  <= i_sb;
    end

    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [NL-1:0][REM_W-1:0] n_rem;
        logic [NL-1:0][QW-1:0]    n_quo;

        always_comb begin
            for (int l = 0; l < NL; l++) begin
                n_rem[l] = {r_rem[g][l][REM_W-2:0], r_low[g][l][QW-1]};
                if (n_rem[l] >= {1'b0, r_dvs[g]}) begin
                    n_rem[l] = n_rem[l] - {1'b0, r_dvs[g]};
                    n_quo[l] = {r_quo[g][l][QW-2:0], 1'b1};
                end else begin
                    n_quo[l] = {r_quo[g][l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            for (int l = 0; l < NL; l++) begin
                r_rem[g+1][l] <= n_rem[l];
                r_low[g+1][l] <= {r_low[g][l][QW-2:0], 1'b0};
                r_quo[g+1][l] <= n_quo[l];
            end
            r_dvs[g+1] <= r_dvs[g];
            r_sb[g+1]  <= r_sb[g];
        end
    end

    assign o_vld = r_vld[QW];
    assign o_quo = r_quo[QW];
    assign o_sb  = r_sb[QW];

endmodule

// File: design/vector_refraction_unit.sv
// Vector refraction unit top level: normalize, Snell refraction or mirror reflection.
// Throughput: one transaction per cycle; the length square root (31 stages), the
// normalizing divider (17 stages) and the cosT2 square root (20 stages) are fully pipelined.
// busy is high during reset and in the cycle after it; otherwise start is always taken.
// Reset (synchronous, active low) clears all valid bits; results cannot be stalled.
`timescale 1ns / 1ps
module vector_refraction_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  vru_pkg::t_in  i_cmd,
    output logic          o_strobe,
    output vru_pkg::t_out o_res
);
    import vru_pkg::*;

    localparam int SQ1_X_W = 2 * IN_W + 2 * NORM_EXTRA;
    localparam int SQ1_RW  = SQ1_X_W / 2;
    localparam int DVD_W   = 45;
    localparam int QW      = 16;
    localparam int SQ2_X_W = 38;
    localparam int SQ2_RW  = SQ2_X_W / 2;
    localparam int LAT     = 3 + (SQ1_RW + 1) + (QW + 1) + 8 + (SQ2_RW + 1) + 4;
    localparam logic signed [ACC_W-1:0] ONE2 = ACC_W'(1) <<< (2 * FRAC_BITS);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(1) <<< (OUT_W - 1));

    typedef struct packed {
        t_in  cmd;
        logic zero;
    } t_sb1;

    typedef struct packed {
        logic [2:0][17:0] v;
        t_in              cmd;
        logic             zero;
    } t_ctx;

    typedef struct packed {
        t_ctx                ctx;
        logic signed [19:0]  cosi;
        logic signed [23:0]  ncos;
        logic                tir;
    } t_sb2;

    logic accept;
    logic r_busy;

    logic r1_vld, r2_vld, r3_vld;
    t_in  r1_cmd, r2_cmd, r3_cmd;
    logic [30:0] r2_sq [3];
    logic [31:0] r3_len2;
    logic        r3_zero;

    logic        w_s1_vld;
    logic [SQ1_RW-1:0] w_s1_root;
    logic [$bits(t_sb1)-1:0] w_s1_sb_vec;
    t_sb1        w_s1_sb;
    logic [2:0][DVD_W-1:0] w_dvd;

    logic        w_d_vld;
    logic [2:0][QW-1:0] w_quo;
    logic [$bits(t_sb1)-1:0] w_d_sb_vec;
    t_sb1        w_d_sb;

    logic        r_v_vld;
    t_ctx        r_v_ctx;
    logic        r_p_vld;
    t_ctx        r_p_ctx;
    logic signed [33:0] r_p_pd [3];
    logic        r_s_vld;
    t_ctx        r_s_ctx;
    logic signed [35:0] r_s_dot;
    logic        r_c_vld;
    t_ctx        r_c_ctx;
    logic signed [19:0] r_c_cosi;
    logic        r_q_vld;
    t_ctx        r_q_ctx;
    logic signed [19:0] r_q_cosi;
    logic signed [39:0] r_q_ci2;
    logic [31:0]        r_q_n2;
    logic signed [36:0] r_q_ncp;
    logic        r_r_vld;
    t_ctx        r_r_ctx;
    logic signed [19:0] r_r_cosi;
    logic signed [23:0] r_r_sin2;
    logic signed [19:0] r_r_nn;
    logic signed [23:0] r_r_ncos;
    logic        r_m_vld;
    t_ctx        r_m_ctx;
    logic signed [19:0] r_m_cosi;
    logic signed [23:0] r_m_ncos;
    logic signed [43:0] r_m_nsp;
    logic        r_t_vld;
    t_sb2        r_t_sb;
    logic [SQ2_X_W-1:0] r_t_ct2;

    logic        w_s2_vld;
    logic [SQ2_RW-1:0] w_s2_root;
    logic [SQ2_RW+1:0] w_s2_rem;
    logic [$bits(t_sb2)-1:0] w_s2_sb_vec;
    t_sb2        w_s2_sb;

    logic        r_k_vld;
    t_sb2        r_k_sb;
    logic signed [25:0] r_k_k;
    logic        r_l_vld, r_l_zero, r_l_tir;
    logic signed [ACC_W-1:0] r_l_pa [3];
    logic signed [ACC_W-1:0] r_l_pb [3];
    logic        r_z_vld, r_z_zero, r_z_tir;
    logic signed [ACC_W-1:0] r_z_sum [3];
    logic        r_o_vld;
    t_out        r_o_res;

    logic signed [IN_W-1:0] n_d1 [3];
    logic signed [IN_W-1:0] n_dd [3];
    logic signed [IN_W-1:0] n_nv_v [3];
    logic signed [IN_W-1:0] n_nv_k [3];
    logic signed [31:0]     n_sq [3];
    logic signed [ACC_W-1:0] n_ct2;
    logic                    n_tir;
    logic signed [25:0]      n_rt;
    logic signed [ACC_W-1:0] n_rnd [3];
    logic signed [OUT_W-1:0] n_out [3];

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_comb begin
        n_d1 = '{r1_cmd.dir_x, r1_cmd.dir_y, r1_cmd.dir_z};
        n_dd = '{w_d_sb.cmd.dir_x, w_d_sb.cmd.dir_y, w_d_sb.cmd.dir_z};
        n_nv_v = '{r_v_ctx.cmd.normal_x, r_v_ctx.cmd.normal_y, r_v_ctx.cmd.normal_z};
        n_nv_k = '{r_k_sb.ctx.cmd.normal_x, r_k_sb.ctx.cmd.normal_y,
                   r_k_sb.ctx.cmd.normal_z};
        for (int i = 0; i < 3; i++) begin
            n_sq[i]  = 32'(n_d1[i]) * 32'(n_d1[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r_v_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_s_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_q_vld <= 1'b0;
            r_r_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_t_vld <= 1'b0;
            r_k_vld <= 1'b0;
            r_l_vld <= 1'b0;
            r_z_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r1_vld  <= accept;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r_v_vld <= w_d_vld;
            r_p_vld <= r_v_vld;
            r_s_vld <= r_p_vld;
            r_c_vld <= r_s_vld;
            r_q_vld <= r_c_vld;
            r_r_vld <= r_q_vld;
            r_m_vld <= r_r_vld;
            r_t_vld <= r_m_vld;
            r_k_vld <= w_s2_vld;
            r_l_vld <= r_k_vld;
            r_z_vld <= r_l_vld;
            r_o_vld <= r_z_vld;
        end
    end

    // front end: squares and squared length
    always_ff @(posedge i_clk) begin
        r1_cmd  <= i_cmd;
        r2_cmd  <= r1_cmd;
        for (int i = 0; i < 3; i++) begin
            r2_sq[i] <= n_sq[i][30:0];
        end
        r3_cmd  <= r2_cmd;
        r3_len2 <= 32'(r2_sq[0]) + 32'(r2_sq[1]) + 32'(r2_sq[2]);
        r3_zero <= (32'(r2_sq[0]) + 32'(r2_sq[1]) + 32'(r2_sq[2])) == 32'd0;
    end

    vru_isqrt_pipe #(
        .X_W  (SQ1_X_W),
        .SB_W ($bits(t_sb1))
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_x     ({r3_len2, (2 * NORM_EXTRA)'(0)}),
        .i_sb    ({r3_cmd, r3_zero}),
        .o_vld   (w_s1_vld),
        .o_root  (w_s1_root),
        .o_rem   (),
        .o_sb    (w_s1_sb_vec)
    );

    assign w_s1_sb = t_sb1'(w_s1_sb_vec);

    logic signed [IN_W-1:0] n_ds [3];
    logic [16:0]            n_dsa [3];
    logic signed [16:0]     n_dsx [3];
    always_comb begin
        n_ds = '{w_s1_sb.cmd.dir_x, w_s1_sb.cmd.dir_y, w_s1_sb.cmd.dir_z};
        for (int i = 0; i < 3; i++) begin
            n_dsx[i] = 17'(n_ds[i]);
            n_dsa[i] = n_dsx[i][16] ? 17'(-n_dsx[i]) : 17'(n_dsx[i]);
            w_dvd[i] = {n_dsa[i], (FRAC_BITS + NORM_EXTRA)'(0)}
                       + DVD_W'(w_s1_root >> 1);
        end
    end

    vru_div_pipe #(
        .NL    (3),
        .DVD_W (DVD_W),
        .DVS_W (SQ1_RW),
        .QW    (QW),
        .SB_W  ($bits(t_sb1))
    ) u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_s1_vld),
        .i_dvd   (w_dvd),
        .i_dvs   (w_s1_root),
        .i_sb    (w_s1_sb_vec),
        .o_vld   (w_d_vld),
        .o_quo   (w_quo),
        .o_sb    (w_d_sb_vec)
    );

    assign w_d_sb = t_sb1'(w_d_sb_vec);

    // cosI, sin2, n*n and cosT2
    always_ff @(posedge i_clk) begin
        r_v_ctx.cmd  <= w_d_sb.cmd;
        r_v_ctx.zero <= w_d_sb.zero;
        for (int i = 0; i < 3; i++) begin
            r_v_ctx.v[i] <= n_dd[i][IN_W-1] ? 18'(-$signed(18'(w_quo[i])))
                                             : 18'(w_quo[i]);
        end

        r_p_ctx <= r_v_ctx;
        for (int i = 0; i < 3; i++) begin
            r_p_pd[i] <= 34'(n_nv_v[i]) * 34'($signed(r_v_ctx.v[i]));
        end

        r_s_ctx <= r_p_ctx;
        r_s_dot <= 36'(r_p_pd[0]) + 36'(r_p_pd[1]) + 36'(r_p_pd[2]);

        r_c_ctx  <= r_s_ctx;
        r_c_cosi <= 20'(round_frac(-ACC_W'(r_s_dot)));

        r_q_ctx  <= r_c_ctx;
        r_q_cosi <= r_c_cosi;
        r_q_ci2  <= 40'(r_c_cosi) * 40'(r_c_cosi);
        r_q_n2   <= 32'(r_c_ctx.cmd.index_ratio) * 32'(r_c_ctx.cmd.index_ratio);
        r_q_ncp  <= 37'($signed({1'b0, r_c_ctx.cmd.index_ratio})) * 37'(r_c_cosi);

        r_r_ctx  <= r_q_ctx;
        r_r_cosi <= r_q_cosi;
        r_r_sin2 <= 24'(round_frac(ONE2 - ACC_W'(r_q_ci2)));
        r_r_nn   <= 20'(round_frac($signed(ACC_W'(r_q_n2))));
        r_r_ncos <= 24'(round_frac(ACC_W'(r_q_ncp)));

        r_m_ctx  <= r_r_ctx;
        r_m_cosi <= r_r_cosi;
        r_m_ncos <= r_r_ncos;
        r_m_nsp  <= 44'(r_r_nn) * 44'(r_r_sin2);

        r_t_sb.ctx  <= r_m_ctx;
        r_t_sb.cosi <= r_m_cosi;
        r_t_sb.ncos <= r_m_ncos;
        r_t_sb.tir  <= n_tir;
        r_t_ct2     <= n_tir ? '0 : SQ2_X_W'(n_ct2);
    end

    always_comb begin
        n_ct2 = ONE2 - ACC_W'(r_m_nsp);
        n_tir = n_ct2 <= 0;
    end

    vru_isqrt_pipe #(
        .X_W  (SQ2_X_W),
        .SB_W ($bits(t_sb2))
    ) u_cos_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_t_vld),
        .i_x     (r_t_ct2),
        .i_sb    (r_t_sb),
        .o_vld   (w_s2_vld),
        .o_root  (w_s2_root),
        .o_rem   (w_s2_rem),
        .o_sb    (w_s2_sb_vec)
    );

    assign w_s2_sb = t_sb2'(w_s2_sb_vec);

    // back end: coefficient, products, sum, round and saturate
    always_comb begin
        n_rt = $signed(26'(w_s2_root))
             + $signed(26'(w_s2_rem > (SQ2_RW + 2)'(w_s2_root)));
        for (int i = 0; i < 3; i++) begin
            n_rnd[i] = round_frac(r_z_sum[i]);
            if (n_rnd[i] > SAT_MAX) begin
                n_out[i] = OUT_W'(SAT_MAX);
            end else if (n_rnd[i] < SAT_MIN) begin
                n_out[i] = OUT_W'(SAT_MIN);
            end else begin
                n_out[i] = OUT_W'(n_rnd[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k_sb <= w_s2_sb;
        r_k_k  <= 26'(w_s2_sb.ncos) - n_rt;

        r_l_zero <= r_k_sb.ctx.zero;
        r_l_tir  <= r_k_sb.tir;
        for (int i = 0; i < 3; i++) begin
            if (r_k_sb.tir) begin
                r_l_pa[i] <= ACC_W'($signed(r_k_sb.ctx.v[i])) <<< FRAC_BITS;
                r_l_pb[i] <= (ACC_W'(r_k_sb.cosi) * ACC_W'(n_nv_k[i])) <<< 1;
            end else begin
                r_l_pa[i] <= ACC_W'($signed(r_k_sb.ctx.v[i]))
                           * ACC_W'($signed({1'b0, r_k_sb.ctx.cmd.index_ratio}));
                r_l_pb[i] <= ACC_W'(n_nv_k[i]) * ACC_W'(r_k_k);
            end
        end

        r_z_zero <= r_l_zero;
        r_z_tir  <= r_l_tir;
        for (int i = 0; i < 3; i++) begin
            r_z_sum[i] <= r_l_pa[i] + r_l_pb[i];
        end

        r_o_res.out_x     <= r_z_zero ? '0 : n_out[0];
        r_o_res.out_y     <= r_z_zero ? '0 : n_out[1];
        r_o_res.out_z     <= r_z_zero ? '0 : n_out[2];
        r_o_res.refracted <= !r_z_zero && !r_z_tir;
    end

    assign o_strobe = r_o_vld;
    assign o_res    = r_o_res;

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_strobe)
        else $error("accepted transaction did not complete at fixed latency");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##LAT !o_strobe)
        else $error("result strobe without an accepted transaction");

    a_zero_vec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_vld && r3_zero) |-> ##(LAT - 3)
        (o_strobe && !o_res.refracted && o_res.out_x == '0 && o_res.out_y == '0
         && o_res.out_z == '0))
        else $error("zero incident vector did not give a zero result");

    a_tir_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_t_vld && r_t_sb.tir) |-> ##(SQ2_RW + 5) (o_strobe && !o_res.refracted))
        else $error("total internal reflection flagged as refraction");
`endif

endmodule

// File: tb/tb_top.sv
// Testbench for the vector refraction unit: directed table plus random rays, checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
    import vru_pkg::*;

    localparam int LATENCY   = 83;
    localparam int N_RANDOM  = 800;
    localparam int MAX_CYCLE = 200000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_cmd;
    logic o_strobe;
    t_out o_res;

    vector_refraction_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_strobe(o_strobe), .o_res(o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    t_out ray_expect_q[$];
    int   mismatch_cnt;
    int   cycle_cnt;

    function automatic longint rnd_shift(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint rnd_div(longint num, longint d);
        longint m;
        m = (num < 0) ? -num : num;
        m = (m + d / 2) / d;
        return (num < 0) ? -m : m;
    endfunction

    function automatic longint sqrt_floor(longint x);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp20(longint v);
        if (v > 524287) return 20'sd524287;
        if (v < -524288) return -20'sd524288;
        return v[OUT_W-1:0];
    endfunction

    function automatic t_out refract_ray(t_in c);
        longint d[3], nv[3], v[3], r[3];
        longint n, len2, s, dot, cos_i, sin2, nn, cos_t2, one2, k, q;
        t_out o;
        d[0] = longint'(c.dir_x);
        d[1] = longint'(c.dir_y);
        d[2] = longint'(c.dir_z);
        nv[0] = longint'(c.normal_x);
        nv[1] = longint'(c.normal_y);
        nv[2] = longint'(c.normal_z);
        n = longint'(c.index_ratio);
        o = '0;
        len2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        if (len2 == 0) return o;
        s = sqrt_floor(len2 <<< (2 * NORM_EXTRA));
        for (int i = 0; i < 3; i++)
            v[i] = rnd_div(d[i] * (64'sd1 <<< (FRAC_BITS + NORM_EXTRA)), s);
        dot = nv[0] * v[0] + nv[1] * v[1] + nv[2] * v[2];
        cos_i = rnd_shift(-dot, FRAC_BITS);
        one2 = 64'sd1 <<< (2 * FRAC_BITS);
        sin2 = rnd_shift(one2 - cos_i * cos_i, FRAC_BITS);
        nn = rnd_shift(n * n, FRAC_BITS);
        cos_t2 = one2 - nn * sin2;
        if (cos_t2 <= 0) begin
            for (int i = 0; i < 3; i++)
                r[i] = rnd_shift(v[i] * (64'sd1 <<< FRAC_BITS) + 2 * cos_i * nv[i], FRAC_BITS);
            o.refracted = 1'b0;
        end else begin
            q = sqrt_floor(cos_t2);
            if (cos_t2 - q * q > q) q++;
            k = rnd_shift(n * cos_i, FRAC_BITS) - q;
            for (int i = 0; i < 3; i++)
                r[i] = rnd_shift(v[i] * n + nv[i] * k, FRAC_BITS);
            o.refracted = 1'b1;
        end
        o.out_x = clamp20(r[0]);
        o.out_y = clamp20(r[1]);
        o.out_z = clamp20(r[2]);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
        mismatch_cnt++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_strobe) begin
            if (ray_expect_q.size() == 0) begin
                report_mismatch("unexpected result", 64'sd0, 64'sd0);
            end else begin
                e = ray_expect_q.pop_front();
                if (o_res.out_x !== e.out_x)
                    report_mismatch("out_x", longint'(o_res.out_x), longint'(e.out_x));
                if (o_res.out_y !== e.out_y)
                    report_mismatch("out_y", longint'(o_res.out_y), longint'(e.out_y));
                if (o_res.out_z !== e.out_z)
                    report_mismatch("out_z", longint'(o_res.out_z), longint'(e.out_z));
                if (o_res.refracted !== e.refracted)
                    report_mismatch("refracted", longint'(o_res.refracted),
                                    longint'(e.refracted));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("Mismatches found");
            $finish;
        end
    end

    typedef struct {
        t_in  cmd;
        bit   has_exp;
        t_out exp_res;
    } t_dir_row;

    t_dir_row dir_tab[$];

    function automatic t_in mk_cmd(int dx, int dy, int dz, int nx, int ny, int nz, int n);
        t_in c;
        c.dir_x = 16'(dx); c.dir_y = 16'(dy); c.dir_z = 16'(dz);
        c.normal_x = 16'(nx); c.normal_y = 16'(ny); c.normal_z = 16'(nz);
        c.index_ratio = 16'(n);
        return c;
    endfunction

    function automatic t_in rand_ray(bit unit_normal);
        t_in c;
        int  axis, sg;
        c.dir_x = 16'($urandom); c.dir_y = 16'($urandom); c.dir_z = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            c.dir_x = 16'($urandom_range(0, 6) - 3);
            c.dir_y = 16'($urandom_range(0, 6) - 3);
            c.dir_z = 16'($urandom_range(0, 6) - 3);
        end
        if (unit_normal) begin
            axis = $urandom_range(0, 3);
            sg = $urandom_range(0, 1) ? 16384 : -16384;
            c.normal_x = '0; c.normal_y = '0; c.normal_z = '0;
            case (axis)
                0: c.normal_x = 16'(sg);
                1: c.normal_y = 16'(sg);
                2: c.normal_z = 16'(sg);
                default: begin
                    // roughly unit, in a diagonal direction
                    c.normal_x = 16'(($urandom_range(0, 1) ? 9459 : -9459)
                                     + $urandom_range(0, 8) - 4);
                    c.normal_y = 16'(($urandom_range(0, 1) ? 9459 : -9459)
                                     + $urandom_range(0, 8) - 4);
                    c.normal_z = 16'(($urandom_range(0, 1) ? 9459 : -9459)
                                     + $urandom_range(0, 8) - 4);
                end
            endcase
        end else begin
            c.normal_x = 16'($urandom_range(0, 32768) - 16384);
            c.normal_y = 16'($urandom_range(0, 32768) - 16384);
            c.normal_z = 16'($urandom_range(0, 32768) - 16384);
        end
        case ($urandom_range(0, 3))
            0: c.index_ratio = 16'($urandom_range(8000, 25000));
            1: c.index_ratio = 16'($urandom_range(0, 16384));
            default: c.index_ratio = 16'($urandom);
        endcase
        return c;
    endfunction

    task automatic send_ray(t_in c, bit do_idle);
        if (do_idle) begin
            while ($urandom_range(0, 99) < 21) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ray_expect_q.push_back(refract_ray(c));
    endtask

    initial begin
        t_out z, e;
        int   wait_cnt;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;

        z = '0;
        dir_tab.push_back('{mk_cmd(0, 0, 0, 0, 0, 16384, 16384), 1'b1, z});
        dir_tab.push_back('{mk_cmd(0, 0, 0, -16384, 16384, -16384, 65535), 1'b1, z});
        // straight through at n = 1
        e = '0; e.out_z = -20'sd16384; e.refracted = 1'b1;
        dir_tab.push_back('{mk_cmd(0, 0, -16384, 0, 0, 16384, 16384), 1'b1, e});
        dir_tab.push_back('{mk_cmd(-32768, -32768, -32768, 16384, 16384, 16384, 16384), 1'b0, z});
        dir_tab.push_back('{mk_cmd(32767, 32767, 32767, -16384, -16384, -16384, 0), 1'b0, z});
        dir_tab.push_back('{mk_cmd(32767, 0, -32768, 0, 0, 16384, 65535), 1'b0, z});
        dir_tab.push_back('{mk_cmd(16384, 0, -1, 0, 0, 16384, 24576), 1'b0, z});
        dir_tab.push_back('{mk_cmd(16384, 0, -16384, 0, 0, 16384, 24576), 1'b0, z});
        dir_tab.push_back('{mk_cmd(16384, 0, -16384, 0, 0, 16384, 23170), 1'b0, z});
        dir_tab.push_back('{mk_cmd(16384, 0, -16384, 0, 0, 16384, 23171), 1'b0, z});
        dir_tab.push_back('{mk_cmd(1, 0, 0, 0, 0, 16384, 16384), 1'b0, z});
        dir_tab.push_back('{mk_cmd(0, -1, 0, 0, 16384, 0, 12000), 1'b0, z});
        dir_tab.push_back('{mk_cmd(1000, 2000, -3000, 8000, 8000, 8000, 20000), 1'b0, z});
        dir_tab.push_back('{mk_cmd(5000, -7000, 9000, 0, -16384, 0, 65535), 1'b0, z});
        dir_tab.push_back('{mk_cmd(-32768, 32767, 100, 16384, -16384, 16384, 65535), 1'b0, z});
        dir_tab.push_back('{mk_cmd(300, 400, -500, 0, 0, 0, 30000), 1'b0, z});
        dir_tab.push_back('{mk_cmd(-1, -1, -1, 16384, 0, 0, 1), 1'b0, z});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            start <= 1'b1;
            i_cmd <= dir_tab[i].cmd;
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
            if (dir_tab[i].has_exp) ray_expect_q.push_back(dir_tab[i].exp_res);
            else ray_expect_q.push_back(refract_ray(dir_tab[i].cmd));
        end
        start <= 1'b0;

        // hold off until the pipeline drains
        while (ray_expect_q.size() != 0) @(posedge i_clk);

        for (int i = 0; i < N_RANDOM; i++) begin
            send_ray(rand_ray($urandom_range(0, 9) != 0), !(i >= 300 && i < 450));
        end
        start <= 1'b0;

        while (ray_expect_q.size() != 0) @(posedge i_clk);
        wait_cnt = 0;
        while (wait_cnt < LATENCY + 20) begin
            @(posedge i_clk);
            wait_cnt++;
        end

        if (mismatch_cnt == 0 && ray_expect_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: filelist.f
design/vru_pkg.sv
design/vru_isqrt_pipe.sv
design/vru_div_pipe.sv
design/vector_refraction_unit.sv
tb/tb_top.sv
